### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the chunked transfer receiver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CTR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ctr assertion failed");

// Checked on every rising clock edge, reset included.
`define CTR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ctr assertion failed");

`endif

### hw/rtl/ctr_pkg.sv
// ----------------------------------------------------------------------------
// Chunked transfer receiver package
// Shared types and constants for the receiver core and its submodules.
// ----------------------------------------------------------------------------
package ctr_pkg;

  // Packet kinds on the input channel.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2,
    OP_OTHER = 2'd3
  } opcode_t;

  // Transfer phase reported with every result.
  typedef enum logic [2:0] {
    PH_WAIT_START = 3'd0,
    PH_RECEIVING  = 3'd1,
    PH_WAIT_END   = 3'd2,
    PH_DONE       = 3'd3,
    PH_ERROR      = 3'd4
  } phase_t;

  // Kinds of acknowledgement.
  typedef enum logic [1:0] {
    KIND_START_ACK = 2'd0,
    KIND_CHUNK_ACK = 2'd1,
    KIND_END_ACK   = 2'd2
  } kind_t;

  // Start status codes.
  localparam logic START_OK  = 1'b0;
  localparam logic START_ERR = 1'b1;

  // Ceiling division: 48-bit size plus 32-bit chunk size gives a 49-bit dividend.
  localparam int TOTAL_W    = 48;
  localparam int CHUNK_W    = 32;
  localparam int DIVIDEND_W = TOTAL_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Number of results pushed for one packet.
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  // One input beat.
  typedef struct packed {
    opcode_t             opcode;
    logic                batch_end;
    logic                name_present;
    logic                hash_present;
    logic [TOTAL_W-1:0]  total_bytes;
    logic [CHUNK_W-1:0]  bytes_per_chunk;
    logic [31:0]         announced_chunks;
    logic [31:0]         chunk_number;
    logic                payload_nonempty;
    logic                digest_ok;
    logic                end_hash_matches_start;
    logic                storage_ok;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    kind_t       message_kind;
    logic        start_status;
    logic [31:0] ack_number;
    phase_t      phase;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;          // handle the accepted beat in this cycle
    logic latch_start;   // hold the start beat and launch the divider
    logic finish_start;  // divider done: decide the held start beat
  } ctr_cmd_t;

  // Status from the datapath side to the controller.
  typedef struct packed {
    logic needs_div;     // the offered beat is a start that must be checked
    logic div_done;      // quotient is ready
  } ctr_status_t;

endpackage

### hw/rtl/ctr_if.sv
// ----------------------------------------------------------------------------
// Chunked transfer receiver channels
// Valid/ready interfaces for the packet input and the acknowledgement output.
// ----------------------------------------------------------------------------
interface ctr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        batch_end;
  logic        name_present;
  logic        hash_present;
  logic [47:0] total_bytes;
  logic [31:0] bytes_per_chunk;
  logic [31:0] announced_chunks;
  logic [31:0] chunk_number;
  logic        payload_nonempty;
  logic        digest_ok;
  logic        end_hash_matches_start;
  logic        storage_ok;

  modport source (
    output valid, opcode, batch_end, name_present, hash_present, total_bytes,
           bytes_per_chunk, announced_chunks, chunk_number, payload_nonempty,
           digest_ok, end_hash_matches_start, storage_ok,
    input  ready
  );

  modport sink (
    input  valid, opcode, batch_end, name_present, hash_present, total_bytes,
           bytes_per_chunk, announced_chunks, chunk_number, payload_nonempty,
           digest_ok, end_hash_matches_start, storage_ok,
    output ready
  );
endinterface

interface ctr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  message_kind;
  logic        start_status;
  logic [31:0] ack_number;
  logic [2:0]  phase;
  logic        last;

  modport source (
    output valid, message_kind, start_status, ack_number, phase, last,
    input  ready
  );

  modport sink (
    input  valid, message_kind, start_status, ack_number, phase, last,
    output ready
  );
endinterface

### hw/rtl/ctr_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider, one quotient bit per cycle, for the start chunk count.
// ----------------------------------------------------------------------------
module ctr_div import ctr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [CHUNK_W-1:0]    divisor,
  output logic                  done,
  output logic [31:0]           quotient
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CHUNK_W-1:0]    rem_r, rem_nxt;
  logic [CHUNK_W-1:0]    dsr_r, dsr_nxt;
  logic [DIVIDEND_W-1:0] dq_r, dq_nxt;
  logic [CHUNK_W:0]      shifted;
  logic [CHUNK_W+1:0]    diff;

  // One trial subtraction per cycle.
  always_comb begin
    shifted  = {rem_r, dq_r[DIVIDEND_W-1]};
    diff     = {1'b0, shifted} - {2'b00, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dq_nxt   = dq_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W - 1);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      dq_nxt   = dividend;
    end else if (busy_r) begin
      if (!diff[CHUNK_W+1]) begin
        rem_nxt = diff[CHUNK_W-1:0];
        dq_nxt  = {dq_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[CHUNK_W-1:0];
        dq_nxt  = {dq_r[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the operands are plain payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dq_r  <= dq_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r[31:0];

endmodule

### hw/rtl/ctr_ctrl.sv
// ----------------------------------------------------------------------------
// Receiver controller
// Sequences beat acceptance and the long start check.
// ----------------------------------------------------------------------------
module ctr_ctrl import ctr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        space_ok,
  input  ctr_status_t status,
  output logic        in_ready,
  output ctr_cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Beats are taken only while idle and with room for two results.
  assign in_ready = (state_r == ST_IDLE) && space_ok;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (status.needs_div) begin
            cmd.latch_start = 1'b1;
            state_nxt       = ST_DIVIDE;
          end else begin
            cmd.take = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          cmd.finish_start = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/ctr_dp.sv
// ----------------------------------------------------------------------------
// Receiver datapath
// Transfer state, packet checks and result formation.
// ----------------------------------------------------------------------------
module ctr_dp import ctr_pkg::*; #(
  parameter int SEQ_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  ctr_cmd_t              cmd,
  input  logic [31:0]           quotient,
  output logic                  needs_div,
  output logic [DIVIDEND_W-1:0] div_dividend,
  output logic [1:0]            push_n,
  output result_t               res0,
  output result_t               res1
);

  phase_t              phase_r, phase_nxt;
  logic [SEQ_BITS-1:0] next_r, next_nxt;
  logic [SEQ_BITS-1:0] total_r, total_nxt;
  logic                had_data_r, had_data_nxt;
  logic                blocked_r, blocked_nxt;
  in_item_t            held_r;
  in_item_t            item;
  logic                start_ok;
  logic                has_op_ack;
  kind_t               op_kind;
  logic                op_status;
  logic                has_chunk_ack;
  logic                active;

  // A start in the wait-start phase goes through the divider unless blocked.
  assign needs_div    = (in_item.opcode == OP_START) && (phase_r == PH_WAIT_START)
                        && !blocked_r;
  assign div_dividend = DIVIDEND_W'(in_item.total_bytes)
                      + DIVIDEND_W'(in_item.bytes_per_chunk) - DIVIDEND_W'(1);

  // Hold the start beat while its chunk count is divided out.
  always_ff @(posedge clk) begin
    if (cmd.latch_start) begin
      held_r <= in_item;
    end
  end

  assign item   = cmd.finish_start ? held_r : in_item;
  assign active = cmd.take || cmd.finish_start;

  // Soundness of a start beat, valid once the quotient is ready.
  assign start_ok = item.name_present && item.hash_present
                 && (item.total_bytes != '0) && (item.bytes_per_chunk != '0)
                 && (item.announced_chunks != '0)
                 && (item.announced_chunks == quotient)
                 && ((item.announced_chunks >> SEQ_BITS) == '0)
                 && item.storage_ok;

  // Next transfer state and the acknowledgements of one beat.
  always_comb begin
    phase_nxt     = phase_r;
    next_nxt      = next_r;
    total_nxt     = total_r;
    had_data_nxt  = had_data_r;
    blocked_nxt   = blocked_r;
    has_op_ack    = 1'b0;
    op_kind       = KIND_START_ACK;
    op_status     = START_OK;
    has_chunk_ack = 1'b0;
    if (!blocked_r) begin
      unique case (item.opcode)
        OP_START: begin
          if (phase_r == PH_WAIT_START) begin
            has_op_ack = 1'b1;
            if (start_ok) begin
              total_nxt = item.announced_chunks[SEQ_BITS-1:0];
              next_nxt  = '0;
              phase_nxt = PH_RECEIVING;
            end else begin
              op_status = START_ERR;
              phase_nxt = PH_ERROR;
            end
          end else if (phase_r == PH_RECEIVING) begin
            has_op_ack = 1'b1;
          end
        end
        OP_DATA: begin
          had_data_nxt = 1'b1;
          if ((phase_r == PH_RECEIVING) && (item.chunk_number == 32'(next_r))
              && (next_r < total_r) && item.payload_nonempty && item.digest_ok) begin
            next_nxt = next_r + 1'b1;
            if (next_nxt == total_r) begin
              phase_nxt = PH_WAIT_END;
            end
          end
        end
        OP_END: begin
          if (phase_r == PH_DONE) begin
            has_op_ack = 1'b1;
            op_kind    = KIND_END_ACK;
          end else if (phase_r == PH_WAIT_END) begin
            if (item.hash_present && item.end_hash_matches_start
                && item.digest_ok && item.storage_ok) begin
              has_op_ack = 1'b1;
              op_kind    = KIND_END_ACK;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_ERROR;
            end
          end
        end
        default: ;
      endcase
    end
    // Batch close: cumulative acknowledgement and blocking decision.
    if (item.batch_end) begin
      if (!blocked_r && had_data_nxt
          && ((phase_nxt == PH_RECEIVING) || (phase_nxt == PH_WAIT_END))) begin
        has_chunk_ack = 1'b1;
      end
      had_data_nxt = 1'b0;
      blocked_nxt  = (phase_nxt == PH_ERROR);
    end
  end

  // Order the results: the packet's own acknowledgement comes first.
  always_comb begin
    res1.message_kind = KIND_CHUNK_ACK;
    res1.start_status = START_OK;
    res1.ack_number   = 32'(next_nxt);
    res1.phase        = phase_nxt;
    res1.last         = 1'b1;
    if (has_op_ack) begin
      res0.message_kind = op_kind;
      res0.start_status = op_status;
      res0.ack_number   = '0;
      res0.phase        = phase_nxt;
      res0.last         = !has_chunk_ack;
    end else begin
      res0 = res1;
    end
    if (!active) begin
      push_n = PUSH_NONE;
    end else if (has_op_ack && has_chunk_ack) begin
      push_n = PUSH_TWO;
    end else if (has_op_ack || has_chunk_ack) begin
      push_n = PUSH_ONE;
    end else begin
      push_n = PUSH_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT_START;
      next_r     <= '0;
      total_r    <= '0;
      had_data_r <= 1'b0;
      blocked_r  <= 1'b0;
    end else if (active) begin
      phase_r    <= phase_nxt;
      next_r     <= next_nxt;
      total_r    <= total_nxt;
      had_data_r <= had_data_nxt;
      blocked_r  <= blocked_nxt;
    end
  end

endmodule

### hw/rtl/ctr_outq.sv
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue that takes up to two results a cycle and sends one.
// ----------------------------------------------------------------------------
module ctr_outq import ctr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  result_t    d0,
  input  result_t    d1,
  output logic       space_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data
);

  localparam int Depth = 4;

  result_t                  entry_r [Depth];
  logic [$clog2(Depth)-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [$clog2(Depth):0]   cnt_r, cnt_nxt;
  logic                     pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = entry_r[rd_r];
  assign pop       = out_valid && out_ready;
  // Room for the two results one beat may cause.
  assign space_ok  = (cnt_r <= ($clog2(Depth)+1)'(Depth - 2));

  always_comb begin
    wr_nxt  = wr_r + push_n;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_n} - {2'b00, pop};
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push_n != PUSH_NONE) begin
      entry_r[wr_r] <= d0;
    end
    if (push_n == PUSH_TWO) begin
      entry_r[wr_r + 1'b1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/chunked_transfer_receiver_core.sv
// ----------------------------------------------------------------------------
// Chunked transfer receiver core
// Receiver side of an in-order chunked transfer: packet checks and acks.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one packet per beat (start, data, end or other) with the
//   outcome flags of hashing and storage. out_chan carries acknowledgements:
//   start, cumulative chunk and end acks, each with the phase after the packet
//   and a last flag on the final result of that packet.
//   A packet causes zero, one or two results. A packet that needs no division
//   is handled in its cycle of acceptance, so one beat a cycle is taken while
//   the result queue has room for two results; its results are queued on
//   acceptance. A start packet in the wait-start phase of an unblocked batch
//   runs through the iterative ceiling divider, one quotient bit a cycle
//   over 49 bits; in_chan.ready stays low until the start ack is pushed.
//   The result queue holds four results; while out_chan.ready is low, beats
//   are still taken until fewer than two entries are free.
//   Reset clears the transfer state to the wait-start phase, empties the
//   queue and stops a running division.
// ----------------------------------------------------------------------------
module chunked_transfer_receiver_core import ctr_pkg::*; #(
  parameter int SEQ_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ctr_in_if.sink    in_chan,
  ctr_out_if.source out_chan
);

  in_item_t              in_item;
  ctr_cmd_t              cmd;
  ctr_status_t           status;
  logic                  needs_div;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [31:0]           quotient;
  logic [1:0]            push_n;
  result_t               res0, res1;
  result_t               head;
  logic                  space_ok;
  logic                  in_ready;

  // Gather the input beat.
  assign in_item.opcode                 = opcode_t'(in_chan.opcode);
  assign in_item.batch_end              = in_chan.batch_end;
  assign in_item.name_present           = in_chan.name_present;
  assign in_item.hash_present           = in_chan.hash_present;
  assign in_item.total_bytes            = in_chan.total_bytes;
  assign in_item.bytes_per_chunk        = in_chan.bytes_per_chunk;
  assign in_item.announced_chunks       = in_chan.announced_chunks;
  assign in_item.chunk_number           = in_chan.chunk_number;
  assign in_item.payload_nonempty       = in_chan.payload_nonempty;
  assign in_item.digest_ok              = in_chan.digest_ok;
  assign in_item.end_hash_matches_start = in_chan.end_hash_matches_start;
  assign in_item.storage_ok             = in_chan.storage_ok;

  assign status.needs_div = needs_div;
  assign status.div_done  = div_done;
  assign in_chan.ready    = in_ready;

  ctr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .space_ok (space_ok),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ctr_dp #(
    .SEQ_BITS (SEQ_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_item      (in_item),
    .cmd          (cmd),
    .quotient     (quotient),
    .needs_div    (needs_div),
    .div_dividend (div_dividend),
    .push_n       (push_n),
    .res0         (res0),
    .res1         (res1)
  );

  ctr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.latch_start),
    .dividend (div_dividend),
    .divisor  (in_item.bytes_per_chunk),
    .done     (div_done),
    .quotient (quotient)
  );

  ctr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .d0        (res0),
    .d1        (res1),
    .space_ok  (space_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (head)
  );

  // Present the queue head.
  assign out_chan.message_kind = head.message_kind;
  assign out_chan.start_status = head.start_status;
  assign out_chan.ack_number   = head.ack_number;
  assign out_chan.phase        = head.phase;
  assign out_chan.last         = head.last;

endmodule

### hw/rtl/ctr_checker.sv
// ----------------------------------------------------------------------------
// Receiver port checker
// Assertions on the output channel of the receiver core, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctr_checker import ctr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_message_kind,
  input logic        out_start_status,
  input logic [31:0] out_ack_number,
  input logic [2:0]  out_phase,
  input logic        out_last
);

  // A stalled result beat keeps its contents.
  `CTR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_message_kind) && $stable(out_start_status) && $stable(out_ack_number) && $stable(out_phase) && $stable(out_last))

  // Reset leaves no result pending.
  `CTR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

  // A rejected start always leaves the transfer in the error phase.
  `CTR_ASSERT(a_start_err_phase, out_valid && out_message_kind == KIND_START_ACK && out_start_status == START_ERR |-> out_phase == PH_ERROR)

  // An end acknowledgement only reports a completed transfer.
  `CTR_ASSERT(a_end_done, out_valid && out_message_kind == KIND_END_ACK |-> out_phase == PH_DONE && out_last)

  // Only chunk acknowledgements carry a sequence number.
  `CTR_ASSERT(a_ack_zero, out_valid && out_message_kind != KIND_CHUNK_ACK |-> out_ack_number == '0)

endmodule

bind chunked_transfer_receiver_core ctr_checker u_ctr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_message_kind (out_chan.message_kind),
  .out_start_status (out_chan.start_status),
  .out_ack_number   (out_chan.ack_number),
  .out_phase        (out_chan.phase),
  .out_last         (out_chan.last)
);
